>>> rtl/sfs_pkg.sv
// Package for the sequence feature statistics block.
// Holds widths, the sequencer state type and the sample and result payload structs.
// No dependencies.
package sfs_pkg;

    localparam int MAX_FRAMES = 4096;

    localparam int SMP_W  = 16;
    localparam int THR_W  = 15;
    localparam int CNT_W  = 13;
    localparam int TURN_W = 12;
    localparam int SUM_W  = 29;
    localparam int ABS_W  = 28;
    localparam int SQ_W   = 43;
    localparam int NUM_W  = 55;
    localparam int DP_W   = 56;
    localparam int STEP_W = 6;
    localparam int VAR_W  = 31;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(410);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_SQA,
        ST_MD_SET,
        ST_MD_RUN,
        ST_M1_SET,
        ST_M1_RUN,
        ST_M2_SET,
        ST_M2_RUN,
        ST_SUB,
        ST_M3_SET,
        ST_M3_RUN,
        ST_VD_SET,
        ST_VD_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    last;
    } smp_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] mean_value;
        logic [VAR_W-1:0]        variance_value;
        logic [SMP_W-1:0]        value_range;
        logic [TURN_W-1:0]       turn_count;
        logic [CNT_W-1:0]        sample_count;
        logic                    overflow;
    } res_t;

endpackage

>>> rtl/sequence_feature_statistics_unit.sv
// Top level of the sequence feature statistics block.
// Depends on sfs_pkg for widths, state type and sample and result structs.

// Each sample request goes through acceptance, the tracker and min/max update
// with a 16x16 square, then the sum-of-squares add. A sample that carries the
// last mark is followed by a run in which one shared 56-bit add/subtract unit,
// one bit a cycle, performs the mean division (28 steps), n*sumsq (13),
// sum^2 (28), the numerator subtract, n^2 (13) and the variance division (55).
// The result sits in an output register; the next sequence may start while it
// waits to be taken.
module sequence_feature_statistics_unit
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     smp_valid,
    output logic                     smp_ready,
    input  sfs_pkg::smp_t            smp_data,
    output logic                     res_valid,
    input  logic                     res_ready,
    output sfs_pkg::res_t            res_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [sfs_pkg::THR_W-1:0] cfg_data
);

    sfs_pkg::state_t state_reg, state_next;

    logic [sfs_pkg::THR_W-1:0]         thr_reg;
    logic [sfs_pkg::CNT_W-1:0]         count_reg;
    logic signed [sfs_pkg::SUM_W-1:0]  sum_reg;
    logic [sfs_pkg::SQ_W-1:0]          sumsq_reg;
    logic signed [sfs_pkg::SMP_W-1:0]  min_reg;
    logic signed [sfs_pkg::SMP_W-1:0]  max_reg;
    logic signed [sfs_pkg::SMP_W-1:0]  ref_reg;
    logic signed [sfs_pkg::SMP_W-1:0]  piv_reg;
    logic                              piv_vld_reg;
    logic [sfs_pkg::TURN_W-1:0]        turns_reg;
    logic                              ovf_reg;
    logic                              res_valid_reg;

    logic signed [sfs_pkg::SMP_W-1:0]  smp_reg;
    logic                              last_reg;
    logic                              take_reg;
    logic [2*sfs_pkg::SMP_W-1:0]       sq_reg;
    logic [sfs_pkg::DP_W-1:0]          acc_reg;
    logic [sfs_pkg::DP_W-1:0]          shf_reg;
    logic [sfs_pkg::DP_W-1:0]          opd_reg;
    logic [sfs_pkg::STEP_W-1:0]        cnt_reg;
    logic [sfs_pkg::NUM_W-1:0]         t1_reg;
    logic [sfs_pkg::SMP_W-1:0]         mean_reg;
    sfs_pkg::res_t                     res_reg;

    logic div_mode;
    logic mul_mode;
    logic sub_mode;
    logic out_load;

    logic [sfs_pkg::DP_W-1:0]   add_x;
    logic [sfs_pkg::DP_W-1:0]   add_y;
    logic [sfs_pkg::DP_W:0]     add_sum;
    logic                       add_sub;

    logic [sfs_pkg::ABS_W-1:0]  abs_sum;
    logic signed [sfs_pkg::SMP_W:0] move;
    logic signed [sfs_pkg::SMP_W:0] prev;
    logic [sfs_pkg::SMP_W:0]    mag;
    logic                       is_move;
    logic                       is_rev;
    logic                       last_step;
    logic [sfs_pkg::SMP_W-1:0]  q_mean;

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    assign abs_sum = sum_reg[sfs_pkg::SUM_W-1] ? sfs_pkg::ABS_W'(-sum_reg)
                                               : sfs_pkg::ABS_W'(sum_reg);

    // hysteretic turn tracker
    assign move    = {smp_reg[sfs_pkg::SMP_W-1], smp_reg} - {ref_reg[sfs_pkg::SMP_W-1], ref_reg};
    assign prev    = {ref_reg[sfs_pkg::SMP_W-1], ref_reg} - {piv_reg[sfs_pkg::SMP_W-1], piv_reg};
    assign mag     = move[sfs_pkg::SMP_W] ? (~move + 1'b1) : move;
    assign is_move = mag >= {2'b00, thr_reg};
    assign is_rev  = (prev > 0 && move < 0) || (prev < 0 && move > 0);

    assign last_step = cnt_reg == sfs_pkg::STEP_W'(1);
    assign q_mean    = shf_reg[sfs_pkg::SMP_W-1:0];

    // shared add/subtract unit
    assign add_sub = div_mode | sub_mode;

    always_comb
    begin
        if (sub_mode)
        begin
            add_x = {1'b0, t1_reg};
            add_y = acc_reg;
        end
        else
        begin
            add_x = {acc_reg[sfs_pkg::DP_W-2:0], div_mode & shf_reg[sfs_pkg::DP_W-1]};
            if (mul_mode)
                add_y = shf_reg[sfs_pkg::DP_W-1] ? opd_reg : '0;
            else
                add_y = opd_reg;
        end
    end

    assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                   + {{sfs_pkg::DP_W{1'b0}}, add_sub};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfs_pkg::ST_IDLE:   if (smp_valid) state_next = sfs_pkg::ST_UPD;
            sfs_pkg::ST_UPD:    state_next = sfs_pkg::ST_SQA;
            sfs_pkg::ST_SQA:    state_next = last_reg ? sfs_pkg::ST_MD_SET : sfs_pkg::ST_IDLE;
            sfs_pkg::ST_MD_SET: state_next = sfs_pkg::ST_MD_RUN;
            sfs_pkg::ST_MD_RUN: if (last_step) state_next = sfs_pkg::ST_M1_SET;
            sfs_pkg::ST_M1_SET: state_next = sfs_pkg::ST_M1_RUN;
            sfs_pkg::ST_M1_RUN: if (last_step) state_next = sfs_pkg::ST_M2_SET;
            sfs_pkg::ST_M2_SET: state_next = sfs_pkg::ST_M2_RUN;
            sfs_pkg::ST_M2_RUN: if (last_step) state_next = sfs_pkg::ST_SUB;
            sfs_pkg::ST_SUB:    state_next = sfs_pkg::ST_M3_SET;
            sfs_pkg::ST_M3_SET: state_next = sfs_pkg::ST_M3_RUN;
            sfs_pkg::ST_M3_RUN: if (last_step) state_next = sfs_pkg::ST_VD_SET;
            sfs_pkg::ST_VD_SET: state_next = sfs_pkg::ST_VD_RUN;
            sfs_pkg::ST_VD_RUN: if (last_step) state_next = sfs_pkg::ST_DONE;
            sfs_pkg::ST_DONE:   if (!res_valid_reg || res_ready) state_next = sfs_pkg::ST_IDLE;
            default:            state_next = sfs_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        smp_ready = 1'b0;
        div_mode  = 1'b0;
        mul_mode  = 1'b0;
        sub_mode  = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            sfs_pkg::ST_IDLE:   smp_ready = 1'b1;
            sfs_pkg::ST_MD_RUN: div_mode  = 1'b1;
            sfs_pkg::ST_VD_RUN: div_mode  = 1'b1;
            sfs_pkg::ST_M1_RUN: mul_mode  = 1'b1;
            sfs_pkg::ST_M2_RUN: mul_mode  = 1'b1;
            sfs_pkg::ST_M3_RUN: mul_mode  = 1'b1;
            sfs_pkg::ST_SUB:    sub_mode  = 1'b1;
            sfs_pkg::ST_DONE:   out_load  = !res_valid_reg || res_ready;
            default:            smp_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfs_pkg::ST_IDLE;
            thr_reg       <= sfs_pkg::THR_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            ref_reg       <= '0;
            piv_reg       <= '0;
            piv_vld_reg   <= 1'b0;
            turns_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                thr_reg <= cfg_data;
            if (res_valid_reg && res_ready && !out_load)
                res_valid_reg <= 1'b0;

            case (state_reg)
                sfs_pkg::ST_UPD:
                begin
                    if (count_reg < sfs_pkg::CNT_W'(sfs_pkg::MAX_FRAMES))
                    begin
                        if (count_reg == '0)
                        begin
                            min_reg <= smp_reg;
                            max_reg <= smp_reg;
                            ref_reg <= smp_reg;
                        end
                        else
                        begin
                            if (smp_reg < min_reg)
                                min_reg <= smp_reg;
                            if (smp_reg > max_reg)
                                max_reg <= smp_reg;
                            if (is_move)
                            begin
                                if (piv_vld_reg && is_rev && turns_reg != '1)
                                    turns_reg <= turns_reg + 1'b1;
                                piv_reg     <= ref_reg;
                                piv_vld_reg <= 1'b1;
                                ref_reg     <= smp_reg;
                            end
                        end
                        sum_reg   <= sum_reg + sfs_pkg::SUM_W'(smp_reg);
                        count_reg <= count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                sfs_pkg::ST_SQA:
                begin
                    if (take_reg)
                        sumsq_reg <= sumsq_reg + sfs_pkg::SQ_W'(sq_reg);
                end
                sfs_pkg::ST_DONE:
                begin
                    if (out_load)
                    begin
                        res_valid_reg <= 1'b1;
                        count_reg     <= '0;
                        sum_reg       <= '0;
                        sumsq_reg     <= '0;
                        min_reg       <= '0;
                        max_reg       <= '0;
                        ref_reg       <= '0;
                        piv_reg       <= '0;
                        piv_vld_reg   <= 1'b0;
                        turns_reg     <= '0;
                        ovf_reg       <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath scratch, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sfs_pkg::ST_IDLE:
            begin
                smp_reg  <= smp_data.sample;
                last_reg <= smp_data.last;
            end
            sfs_pkg::ST_UPD:
            begin
                take_reg <= count_reg < sfs_pkg::CNT_W'(sfs_pkg::MAX_FRAMES);
                sq_reg   <= unsigned'((2*sfs_pkg::SMP_W)'(smp_reg)
                                      * (2*sfs_pkg::SMP_W)'(smp_reg));
            end
            sfs_pkg::ST_MD_SET:
            begin
                acc_reg <= '0;
                opd_reg <= sfs_pkg::DP_W'(count_reg);
                shf_reg <= {abs_sum, {(sfs_pkg::DP_W-sfs_pkg::ABS_W){1'b0}}};
                cnt_reg <= sfs_pkg::STEP_W'(sfs_pkg::ABS_W);
            end
            sfs_pkg::ST_M1_SET:
            begin
                mean_reg <= sum_reg[sfs_pkg::SUM_W-1] ? (~q_mean + 1'b1) : q_mean;
                acc_reg  <= '0;
                opd_reg  <= sfs_pkg::DP_W'(sumsq_reg);
                shf_reg  <= {count_reg, {(sfs_pkg::DP_W-sfs_pkg::CNT_W){1'b0}}};
                cnt_reg  <= sfs_pkg::STEP_W'(sfs_pkg::CNT_W);
            end
            sfs_pkg::ST_M2_SET:
            begin
                t1_reg  <= acc_reg[sfs_pkg::NUM_W-1:0];
                acc_reg <= '0;
                opd_reg <= sfs_pkg::DP_W'(abs_sum);
                shf_reg <= {abs_sum, {(sfs_pkg::DP_W-sfs_pkg::ABS_W){1'b0}}};
                cnt_reg <= sfs_pkg::STEP_W'(sfs_pkg::ABS_W);
            end
            sfs_pkg::ST_SUB:
            begin
                t1_reg <= add_sum[sfs_pkg::NUM_W-1:0];
            end
            sfs_pkg::ST_M3_SET:
            begin
                acc_reg <= '0;
                opd_reg <= sfs_pkg::DP_W'(count_reg);
                shf_reg <= {count_reg, {(sfs_pkg::DP_W-sfs_pkg::CNT_W){1'b0}}};
                cnt_reg <= sfs_pkg::STEP_W'(sfs_pkg::CNT_W);
            end
            sfs_pkg::ST_VD_SET:
            begin
                opd_reg <= acc_reg;
                acc_reg <= '0;
                shf_reg <= {t1_reg, {(sfs_pkg::DP_W-sfs_pkg::NUM_W){1'b0}}};
                cnt_reg <= sfs_pkg::STEP_W'(sfs_pkg::NUM_W);
            end
            sfs_pkg::ST_MD_RUN, sfs_pkg::ST_VD_RUN:
            begin
                // restoring divide, one quotient bit a cycle
                acc_reg <= add_sum[sfs_pkg::DP_W] ? add_sum[sfs_pkg::DP_W-1:0] : add_x;
                shf_reg <= {shf_reg[sfs_pkg::DP_W-2:0], add_sum[sfs_pkg::DP_W]};
                cnt_reg <= cnt_reg - 1'b1;
            end
            sfs_pkg::ST_M1_RUN, sfs_pkg::ST_M2_RUN, sfs_pkg::ST_M3_RUN:
            begin
                // shift-add multiply, multiplier msb first
                acc_reg <= add_sum[sfs_pkg::DP_W-1:0];
                shf_reg <= {shf_reg[sfs_pkg::DP_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            sfs_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    res_reg.mean_value <= mean_reg;
                    if (|shf_reg[sfs_pkg::NUM_W-1:sfs_pkg::VAR_W])
                        res_reg.variance_value <= '1;
                    else
                        res_reg.variance_value <= shf_reg[sfs_pkg::VAR_W-1:0];
                    res_reg.value_range  <= max_reg - min_reg;
                    res_reg.turn_count   <= turns_reg;
                    res_reg.sample_count <= count_reg;
                    res_reg.overflow     <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_rose_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == sfs_pkg::ST_DONE))
        else $error("result raised outside the final state");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sfs_pkg::CNT_W'(sfs_pkg::MAX_FRAMES))
        else $error("sample count beyond capacity");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (smp_valid && smp_ready) |=> !smp_ready)
        else $error("request taken while previous one in progress");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("minimum above maximum");
`endif

endmodule
